FILE: src/tekd_pkg.sv
// Shared types and constants for the terminal escape key decoder.
// Used by every module of the block; depends on nothing.

package tekd_pkg;

   // Request and result payloads.
   typedef struct packed {
      logic       operation;   // 0 received byte, 1 timer tick
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  key_kind;
      logic [7:0]  key_char;
      logic [15:0] report_row;
      logic [15:0] report_col;
      logic        last;
   } rsp_type;

   // Up to two results produced by one request.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } res_pair_type;

   localparam int GAP_W     = 10;
   localparam int SEQ_LEN_W = 6;

   localparam logic [GAP_W-1:0] GAP_TIMEOUT_RESET = 10'd80;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Key kinds.
   localparam logic [3:0] KEY_CHAR       = 4'd0;
   localparam logic [3:0] KEY_UP         = 4'd1;
   localparam logic [3:0] KEY_DOWN       = 4'd2;
   localparam logic [3:0] KEY_RIGHT      = 4'd3;
   localparam logic [3:0] KEY_LEFT       = 4'd4;
   localparam logic [3:0] KEY_HOME       = 4'd5;
   localparam logic [3:0] KEY_END        = 4'd6;
   localparam logic [3:0] KEY_INSERT     = 4'd7;
   localparam logic [3:0] KEY_DELETE     = 4'd8;
   localparam logic [3:0] KEY_PGUP       = 4'd9;
   localparam logic [3:0] KEY_PGDN       = 4'd10;
   localparam logic [3:0] KEY_PASTE_BEG  = 4'd11;
   localparam logic [3:0] KEY_PASTE_END  = 4'd12;
   localparam logic [3:0] KEY_CURSOR_REP = 4'd13;

   // Character codes.
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_B        = 8'h42;
   localparam logic [7:0] CH_C        = 8'h43;
   localparam logic [7:0] CH_D        = 8'h44;
   localparam logic [7:0] CH_F        = 8'h46;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_SS3      = 8'h4F;
   localparam logic [7:0] CH_R        = 8'h52;
   localparam logic [7:0] CH_Z        = 8'h5A;
   localparam logic [7:0] CH_CSI      = 8'h5B;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_FINAL_HI = 8'h7E;

endpackage

FILE: src/tekd_decode.sv
// Decoder state and the single-pass next-state and result logic.
// Depends on tekd_pkg.

module tekd_decode
   import tekd_pkg::*;
#(
   parameter int MAX_SEQ_BYTES = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  req_type          item,
   input  logic [GAP_W-1:0] gap_timeout,
   output res_pair_type     res
);

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_ESC  = 4'b0010,
      MODE_CSI  = 4'b0100,
      MODE_SS3  = 4'b1000
   } mode_type;

   localparam logic [SEQ_LEN_W-1:0] SEQ_LIMIT = SEQ_LEN_W'(MAX_SEQ_BYTES);

   mode_type               mode_ff, mode_in;
   logic [SEQ_LEN_W-1:0]   seq_len_ff, seq_len_in;
   logic [GAP_W-1:0]       gap_ff, gap_in;
   logic [15:0]            cur_ff, cur_in;
   logic                   present_ff, present_in;
   logic [15:0]            first_ff, first_in;
   logic [15:0]            second_ff, second_in;
   logic [1:0]             pcount_ff, pcount_in;

   function automatic logic [3:0] letter_key(input logic [7:0] b);
      logic [3:0] k;
      k = KEY_CHAR;
      unique case (b)
         CH_A:    k = KEY_UP;
         CH_B:    k = KEY_DOWN;
         CH_C:    k = KEY_RIGHT;
         CH_D:    k = KEY_LEFT;
         CH_H:    k = KEY_HOME;
         CH_F:    k = KEY_END;
         default: k = KEY_CHAR;
      endcase
      return k;
   endfunction

   function automatic logic [3:0] tilde_key(input logic [15:0] p);
      logic [3:0] k;
      k = KEY_CHAR;
      unique case (p)
         16'd1, 16'd7: k = KEY_HOME;
         16'd2:        k = KEY_INSERT;
         16'd3:        k = KEY_DELETE;
         16'd4, 16'd8: k = KEY_END;
         16'd5:        k = KEY_PGUP;
         16'd6:        k = KEY_PGDN;
         16'd200:      k = KEY_PASTE_BEG;
         16'd201:      k = KEY_PASTE_END;
         default:      k = KEY_CHAR;
      endcase
      return k;
   endfunction

   function automatic rsp_type mk_rsp(input logic [3:0] kind, input logic [7:0] ch,
                                      input logic [15:0] row, input logic [15:0] col,
                                      input logic last);
      rsp_type r;
      r.key_kind   = kind;
      r.key_char   = ch;
      r.report_row = row;
      r.report_col = col;
      r.last       = last;
      return r;
   endfunction

   logic [7:0]           b;
   logic [GAP_W-1:0]     gap_inc;
   logic [SEQ_LEN_W-1:0] len_inc;
   logic [15:0]          cur_eff, p0, p1, mul10;
   logic [3:0]           lkey, tkey, skey;
   logic                 is_final, is_digit, is_sep;

   assign b        = item.data_byte;
   assign gap_inc  = gap_ff + GAP_W'(1);
   assign len_inc  = seq_len_ff + SEQ_LEN_W'(1);
   assign cur_eff  = present_ff ? cur_ff : 16'd0;
   assign p0       = (pcount_ff == 2'd0) ? cur_eff : first_ff;
   assign p1       = (pcount_ff == 2'd1) ? cur_eff : second_ff;
   assign lkey     = letter_key(b);
   assign tkey     = tilde_key(p0);
   assign skey     = letter_key(b);
   assign is_final = (b >= CH_FINAL_LO) && (b <= CH_FINAL_HI);
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign is_sep   = (b == CH_SEMI) || (b == CH_COLON);
   // Times ten as two shifted adds, kept modulo 65536.
   assign mul10    = {cur_ff[12:0], 3'b000} + {cur_ff[14:0], 1'b0};

   always_comb begin
      mode_in    = mode_ff;
      seq_len_in = seq_len_ff;
      gap_in     = gap_ff;
      cur_in     = cur_ff;
      present_in = present_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      pcount_in  = pcount_ff;
      res.count  = 2'd0;
      res.first  = mk_rsp(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b1);
      res.second = mk_rsp(KEY_CHAR, b, 16'd0, 16'd0, 1'b1);

      if (item.operation == OP_TICK) begin
         if (mode_ff != MODE_IDLE) begin
            if (gap_inc >= gap_timeout) begin
               mode_in   = MODE_IDLE;
               gap_in    = '0;
               res.count = 2'd1;
            end else begin
               gap_in = gap_inc;
            end
         end
      end else begin
         gap_in = '0;
         unique case (mode_ff)
            MODE_IDLE: begin
               if (b == CH_ESC) begin
                  mode_in = MODE_ESC;
               end else begin
                  res.count = 2'd1;
                  res.first = mk_rsp(KEY_CHAR, b, 16'd0, 16'd0, 1'b1);
               end
            end
            MODE_ESC: begin
               if (b == CH_CSI) begin
                  mode_in    = MODE_CSI;
                  seq_len_in = '0;
                  cur_in     = '0;
                  present_in = 1'b0;
                  first_in   = '0;
                  second_in  = '0;
                  pcount_in  = '0;
               end else if (b == CH_SS3) begin
                  mode_in = MODE_SS3;
               end else begin
                  // Meta byte: a bare ESC, then the byte itself.
                  mode_in   = MODE_IDLE;
                  res.count = 2'd2;
                  res.first = mk_rsp(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b0);
               end
            end
            MODE_SS3: begin
               mode_in   = MODE_IDLE;
               res.count = 2'd1;
               if (skey != KEY_CHAR) begin
                  res.first = mk_rsp(skey, 8'd0, 16'd0, 16'd0, 1'b1);
               end
            end
            MODE_CSI: begin
               seq_len_in = len_inc;
               if (is_final) begin
                  mode_in   = MODE_IDLE;
                  res.count = 2'd1;
                  if (lkey != KEY_CHAR) begin
                     res.first = mk_rsp(lkey, 8'd0, 16'd0, 16'd0, 1'b1);
                  end else if (b == CH_Z) begin
                     res.first = mk_rsp(KEY_CHAR, CH_TAB, 16'd0, 16'd0, 1'b1);
                  end else if (b == CH_R && pcount_ff != 2'd0) begin
                     res.first = mk_rsp(KEY_CURSOR_REP, 8'd0, p0, p1, 1'b1);
                  end else if (b == CH_TILDE && tkey != KEY_CHAR) begin
                     res.first = mk_rsp(tkey, 8'd0, 16'd0, 16'd0, 1'b1);
                  end
               end else begin
                  if (is_digit) begin
                     cur_in     = mul10 + {12'd0, b[3:0]};
                     present_in = 1'b1;
                  end else if (is_sep) begin
                     if (pcount_ff == 2'd0) begin
                        first_in = cur_eff;
                     end else if (pcount_ff == 2'd1) begin
                        second_in = cur_eff;
                     end
                     if (pcount_ff != 2'd2) begin
                        pcount_in = pcount_ff + 2'd1;
                     end
                     cur_in     = '0;
                     present_in = 1'b0;
                  end
                  // Sequence grew too long without a final byte.
                  if (len_inc >= SEQ_LIMIT) begin
                     mode_in   = MODE_IDLE;
                     res.count = 2'd1;
                  end
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         seq_len_ff <= '0;
         gap_ff     <= '0;
         cur_ff     <= '0;
         present_ff <= 1'b0;
         first_ff   <= '0;
         second_ff  <= '0;
         pcount_ff  <= '0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         seq_len_ff <= seq_len_in;
         gap_ff     <= gap_in;
         cur_ff     <= cur_in;
         present_ff <= present_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         pcount_ff  <= pcount_in;
      end
   end

   // Only the byte after a lone ESC can produce two results.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && res.count == 2'd2) |-> (mode_ff == MODE_ESC))
      else $error("two results outside the ESC mode");

   // A tick while idle never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      (item.operation == OP_TICK && mode_ff == MODE_IDLE) |-> (res.count == 2'd0))
      else $error("result from a tick while idle");

   // An open CSI sequence is always shorter than the limit.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CSI) |-> (seq_len_ff < SEQ_LIMIT))
      else $error("CSI sequence length reached the limit");

endmodule

FILE: src/tekd_rsp_queue.sv
// Two-entry result register queue that decouples the decoder from the
// result channel. Depends on tekd_pkg.

module tekd_rsp_queue
   import tekd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_en,
   input  res_pair_type push_data,
   input  logic         pop_en,
   output logic [1:0]   count,
   output rsp_type      head
);

   rsp_type    e0_ff, e0_in;
   rsp_type    e1_ff, e1_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] fill;

   always_comb begin
      e0_in = e0_ff;
      e1_in = e1_ff;
      fill  = count_ff;
      if (pop_en && count_ff != 2'd0) begin
         e0_in = e1_ff;
         fill  = count_ff - 2'd1;
      end
      count_in = fill;
      if (push_en && push_data.count != 2'd0) begin
         if (fill == 2'd0) begin
            e0_in = push_data.first;
            e1_in = push_data.second;
         end else begin
            e1_in = push_data.first;
         end
         count_in = fill + push_data.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign count = count_ff;
   assign head  = e0_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   // The producer only pushes what fits before this cycle's pop.
   assert property (@(posedge clock) disable iff (reset)
      push_en |-> ({1'b0, push_data.count} + {1'b0, count_ff} <= 3'd2))
      else $error("result queue overflow");

endmodule

FILE: src/terminal_escape_key_decoder_top.sv
// Sustained rate: one request per cycle while the result queue has room. A
// request enters the input register on acceptance and is decoded against the
// sequence state in the next cycle, its results going into a two-entry result
// queue; the first result is valid on rsp once the queue register has taken
// it, which a full queue can delay. ESC followed by a byte other than '['
// or 'O' gives two results, which leave one per cycle while rsp_ready is high,
// so that request holds the input register until the queue is empty, and a
// request after it that gives a result waits until one of the two has left;
// every other request gives at most one result. A low rsp_ready stalls the
// input once the queue is full. The gap timeout register may be written only
// while no request or result is in flight.
//
// Top level of the terminal escape key decoder; depends on tekd_pkg,
// tekd_decode and tekd_rsp_queue.

module terminal_escape_key_decoder_top
   import tekd_pkg::*;
#(
   parameter int MAX_SEQ_BYTES = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          in_item_ff;
   logic [GAP_W-1:0] gap_timeout_ff;
   res_pair_type     dec_res;
   logic [1:0]       q_count;
   logic             step;

   // Advance the held request only when all of its results fit in the queue.
   assign step        = in_valid_ff &&
                        ({1'b0, dec_res.count} + {1'b0, q_count} <= 3'd2);
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);
   assign rsp_valid   = (q_count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         gap_timeout_ff <= GAP_TIMEOUT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            gap_timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   tekd_decode #(
      .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step),
      .item       (in_item_ff),
      .gap_timeout(gap_timeout_ff),
      .res        (dec_res)
   );

   tekd_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (step),
      .push_data(dec_res),
      .pop_en   (rsp_ready),
      .count    (q_count),
      .head     (rsp_payload)
   );

   // The ESC of a meta pair is always followed by its byte in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> (q_count == 2'd2))
      else $error("non-final result without its partner");

   // A stalled input register means the queue could not take its results.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |-> (q_count != 2'd0))
      else $error("input stalled with an empty result queue");

   assert property (@(posedge clock) disable iff (reset)
      step |-> in_valid_ff)
      else $error("decoder stepped without a request");

endmodule

FILE: dv/tekd_key_event_checker.sv
// Key event checker for the terminal escape key decoder: predicts the results of
// every accepted request and compares them with the rsp channel.
// Depends on tekd_pkg.

module tekd_key_event_checker
   import tekd_pkg::*;
#(
   parameter int MAX_SEQ_BYTES = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending_count,
   output int               event_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      SEQ_IDLE      = 4'b0001,
      SEQ_AFTER_ESC = 4'b0010,
      SEQ_CSI       = 4'b0100,
      SEQ_SS3       = 4'b1000
   } seq_mode_type;

   seq_mode_type         seq_mode;
   logic [SEQ_LEN_W-1:0] seq_len;
   logic [GAP_W-1:0]     ticks_since_byte;
   logic [GAP_W-1:0]     gap_limit;
   logic [15:0]          cur_val;
   logic                 have_digit;
   logic [15:0]          row_param;
   logic [15:0]          col_param;
   logic [1:0]           sep_count;

   rsp_type expected_keys[$];
   int      mismatches = 0;
   int      compared = 0;

   function automatic logic [3:0] letter_kind(logic [7:0] b);
      case (b)
         CH_A: return KEY_UP;
         CH_B: return KEY_DOWN;
         CH_C: return KEY_RIGHT;
         CH_D: return KEY_LEFT;
         CH_H: return KEY_HOME;
         CH_F: return KEY_END;
         default: return KEY_CHAR;
      endcase
   endfunction

   function automatic logic [3:0] tilde_kind(logic [15:0] p);
      case (p)
         16'd1, 16'd7: return KEY_HOME;
         16'd2: return KEY_INSERT;
         16'd3: return KEY_DELETE;
         16'd4, 16'd8: return KEY_END;
         16'd5: return KEY_PGUP;
         16'd6: return KEY_PGDN;
         16'd200: return KEY_PASTE_BEG;
         16'd201: return KEY_PASTE_END;
         default: return KEY_CHAR;
      endcase
   endfunction

   task automatic push_key(logic [3:0] kind, logic [7:0] ch, logic [15:0] row,
                           logic [15:0] col, logic last_one);
      rsp_type r;
      r.key_kind   = kind;
      r.key_char   = ch;
      r.report_row = row;
      r.report_col = col;
      r.last       = last_one;
      expected_keys.push_back(r);
   endtask

   task automatic clear_sequence();
      seq_len    = '0;
      cur_val    = '0;
      have_digit = 1'b0;
      row_param  = '0;
      col_param  = '0;
      sep_count  = '0;
   endtask

   task automatic finish_csi(logic [7:0] b);
      logic [15:0] cur;
      logic [15:0] p0;
      logic [15:0] p1;
      cur = have_digit ? cur_val : 16'd0;
      p0  = (sep_count == 2'd0) ? cur : row_param;
      p1  = (sep_count == 2'd1) ? cur : col_param;
      if (letter_kind(b) != KEY_CHAR) begin
         push_key(letter_kind(b), 8'd0, 16'd0, 16'd0, 1'b1);
      end else if (b == CH_Z) begin
         push_key(KEY_CHAR, CH_TAB, 16'd0, 16'd0, 1'b1);
      end else if (b == CH_R && sep_count != 2'd0) begin
         push_key(KEY_CURSOR_REP, 8'd0, p0, p1, 1'b1);
      end else if (b == CH_TILDE && tilde_kind(p0) != KEY_CHAR) begin
         push_key(tilde_kind(p0), 8'd0, 16'd0, 16'd0, 1'b1);
      end else begin
         push_key(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b1);
      end
   endtask

   task automatic decode_request(req_type r);
      logic [7:0]  b;
      logic [31:0] acc;
      logic [15:0] v;
      b = r.data_byte;
      if (r.operation == OP_TICK) begin
         // Ticks only matter while a sequence is pending.
         if (seq_mode != SEQ_IDLE) begin
            ticks_since_byte = ticks_since_byte + 1'b1;
            if (ticks_since_byte >= gap_limit) begin
               seq_mode         = SEQ_IDLE;
               ticks_since_byte = '0;
               push_key(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b1);
            end
         end
      end else begin
         ticks_since_byte = '0;
         case (seq_mode)
            SEQ_IDLE: begin
               if (b == CH_ESC) seq_mode = SEQ_AFTER_ESC;
               else push_key(KEY_CHAR, b, 16'd0, 16'd0, 1'b1);
            end
            SEQ_AFTER_ESC: begin
               if (b == CH_CSI) begin
                  clear_sequence();
                  seq_mode = SEQ_CSI;
               end else if (b == CH_SS3) begin
                  seq_mode = SEQ_SS3;
               end else begin
                  seq_mode = SEQ_IDLE;
                  push_key(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b0);
                  push_key(KEY_CHAR, b, 16'd0, 16'd0, 1'b1);
               end
            end
            SEQ_SS3: begin
               seq_mode = SEQ_IDLE;
               if (letter_kind(b) != KEY_CHAR)
                  push_key(letter_kind(b), 8'd0, 16'd0, 16'd0, 1'b1);
               else
                  push_key(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b1);
            end
            default: begin
               seq_len = seq_len + 1'b1;
               if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
                  seq_mode = SEQ_IDLE;
                  finish_csi(b);
               end else begin
                  if (b >= CH_ZERO && b <= CH_NINE) begin
                     acc        = 32'(cur_val) * 32'd10 + 32'(b) - 32'(CH_ZERO);
                     cur_val    = acc[15:0];
                     have_digit = 1'b1;
                  end else if (b == CH_SEMI || b == CH_COLON) begin
                     // Only the first two parameters are kept; empty ones read as zero.
                     v = have_digit ? cur_val : 16'd0;
                     if (sep_count == 2'd0) row_param = v;
                     else if (sep_count == 2'd1) col_param = v;
                     if (sep_count < 2'd2) sep_count = sep_count + 1'b1;
                     cur_val    = '0;
                     have_digit = 1'b0;
                  end
                  if (seq_len >= MAX_SEQ_BYTES) begin
                     seq_mode = SEQ_IDLE;
                     push_key(KEY_CHAR, CH_ESC, 16'd0, 16'd0, 1'b1);
                  end
               end
            end
         endcase
      end
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] tekd checker: %s", $time, msg);
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (expected_keys.size() == 0) begin
         report_mismatch("key event arrived with no request pending");
      end else begin
         want = expected_keys.pop_front();
         compared++;
         if (got.key_kind !== want.key_kind)
            report_mismatch($sformatf("key_kind got %0d expected %0d",
                                      got.key_kind, want.key_kind));
         if (got.key_char !== want.key_char)
            report_mismatch($sformatf("key_char got 0x%02h expected 0x%02h",
                                      got.key_char, want.key_char));
         if (got.report_row !== want.report_row)
            report_mismatch($sformatf("report_row got %0d expected %0d",
                                      got.report_row, want.report_row));
         if (got.report_col !== want.report_col)
            report_mismatch($sformatf("report_col got %0d expected %0d",
                                      got.report_col, want.report_col));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b", got.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gap_limit        = GAP_TIMEOUT_RESET;
         seq_mode         = SEQ_IDLE;
         ticks_since_byte = '0;
         clear_sequence();
         expected_keys.delete();
      end else begin
         if (csr_wr_en) gap_limit = csr_wr_data;
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (req_valid && req_ready) decode_request(req_payload);
      end
      fail_count    <= mismatches;
      pending_count <= expected_keys.size();
      event_count   <= compared;
   end

endmodule

FILE: dv/terminal_escape_key_decoder_top_tb.sv
// Testbench top for the terminal escape key decoder: drives byte and tick requests
// and gap timeout settings, and gives the verdict.
// Depends on tekd_pkg, terminal_escape_key_decoder_top and tekd_key_event_checker.

module terminal_escape_key_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tekd_pkg::*;

   localparam int SEQ_LIMIT = 31;
   localparam logic [7:0] ARROW_FINALS [6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
   localparam int TILDE_CODES [10] = '{1, 2, 3, 4, 5, 6, 7, 8, 200, 201};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_wr_en = 1'b0;
   logic [GAP_W-1:0] csr_wr_data = '0;

   int fail_count;
   int pending_count;
   int event_count;

   int sent_count = 0;
   int burst_left = 0;
   int send_style = 0;
   int stall_style = 1;
   int stall_left = 0;
   int stall_tick = 0;
   int setting_count = 0;
   logic [GAP_W-1:0] gap_setting = GAP_TIMEOUT_RESET;

   terminal_escape_key_decoder_top #(.MAX_SEQ_BYTES(SEQ_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tekd_key_event_checker #(.MAX_SEQ_BYTES(SEQ_LIMIT)) key_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .event_count   (event_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure: always ready, random, a fixed pattern, or long stalls.
   always @(posedge clock) begin
      stall_tick++;
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 99) < 70);
         2: rsp_ready <= ((stall_tick % 7) > 2);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 6) begin
               stall_left = $urandom_range(4, 19);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   function automatic int gap_ticks();
      return (gap_setting == '0) ? 1 : int'(gap_setting);
   endfunction

   // Holds one request until it is taken, then maybe ends the burst with a gap.
   task automatic drive_request(logic op, logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= {op, b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (send_style != 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 15);
            gap = (send_style == 1) ? $urandom_range(1, 3) : $urandom_range(2, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic put_byte(logic [7:0] b);
      drive_request(OP_BYTE, b);
   endtask

   task automatic put_ticks(int n);
      repeat (n) drive_request(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic put_number(int v, bit pad);
      string s;
      s = $sformatf("%0d", v);
      if (pad) s = {"0", s};
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_nonfinal();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b >= CH_FINAL_LO && b <= CH_FINAL_HI);
      put_byte(b);
   endtask

   // Some ticks inside a pending sequence, always fewer than the timeout.
   task automatic maybe_pause();
      int most;
      most = (gap_ticks() - 1 < 30) ? gap_ticks() - 1 : 30;
      if (most > 0 && $urandom_range(0, 4) == 0) put_ticks($urandom_range(1, most));
   endtask

   task automatic random_csi();
      int nparams;
      int pick;
      logic [7:0] fin;
      put_byte(CH_ESC);
      put_byte(CH_CSI);
      nparams = $urandom_range(0, 3);
      for (int i = 0; i < nparams; i++) begin
         if (i > 0) put_byte($urandom_range(0, 1) ? CH_SEMI : CH_COLON);
         pick = $urandom_range(0, 9);
         if (pick != 0) begin
            if (pick < 4) put_number(TILDE_CODES[$urandom_range(0, 9)], 1'b0);
            else if (pick < 8) put_number($urandom_range(0, 999), pick == 7);
            else put_number($urandom_range(0, 999999), 1'b0);
         end
         if ($urandom_range(0, 9) == 0) put_nonfinal();
         maybe_pause();
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) fin = ARROW_FINALS[$urandom_range(0, 5)];
      else if (pick < 35) fin = CH_Z;
      else if (pick < 55) fin = CH_R;
      else if (pick < 85) fin = CH_TILDE;
      else fin = 8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI));
      put_byte(fin);
   endtask

   task automatic random_sequence();
      int pick;
      int n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 25) begin
         do b = 8'($urandom_range(0, 255)); while (b == CH_CSI || b == CH_SS3);
         put_byte(CH_ESC);
         maybe_pause();
         put_byte(b);
      end else if (pick < 65) begin
         random_csi();
      end else if (pick < 75) begin
         put_byte(CH_ESC);
         put_byte(CH_SS3);
         maybe_pause();
         put_byte(($urandom_range(0, 4) != 0) ? ARROW_FINALS[$urandom_range(0, 5)]
                                              : 8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
         // Runs into the length limit, or stops one byte short of it with a final.
         put_byte(CH_ESC);
         put_byte(CH_CSI);
         n = $urandom_range(0, 1) ? SEQ_LIMIT : SEQ_LIMIT - 1;
         repeat (n) put_nonfinal();
         if (n < SEQ_LIMIT) put_byte(ARROW_FINALS[$urandom_range(0, 5)]);
      end else if (pick < 88) begin
         // A sequence left hanging; with a long timeout a late byte rescues it.
         put_byte(CH_ESC);
         n = $urandom_range(0, 2);
         if (n == 1) begin
            put_byte(CH_CSI);
            put_number($urandom_range(0, 99), 1'b0);
         end else if (n == 2) begin
            put_byte(CH_SS3);
         end
         if (gap_ticks() <= 100) begin
            put_ticks(gap_ticks());
         end else begin
            put_ticks($urandom_range(1, 40));
            put_byte(ARROW_FINALS[$urandom_range(0, 5)]);
         end
      end else if (pick < 94) begin
         put_ticks($urandom_range(1, 4));
      end else begin
         repeat ($urandom_range(1, 4))
            drive_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
   endtask

   // Waits for every expected key event, then lets a request with no result drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic settle_and_write(logic [GAP_W-1:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gap_setting = v;
      setting_count++;
   endtask

   initial begin
      logic [GAP_W-1:0] phase_values [6];
      int target;
      phase_values = '{10'd1, 10'd0, 10'd1023, 10'd3, 10'($urandom_range(2, 60)),
                       GAP_TIMEOUT_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      put_byte(8'h00);
      put_byte(8'hFF);
      put_ticks(1);
      put_byte(CH_ESC);
      put_byte(CH_ESC);
      put_byte(CH_ESC);
      put_byte(CH_CSI);
      put_byte(CH_A);
      put_byte(CH_ESC);
      put_byte(CH_SS3);
      put_byte(8'h50);
      put_byte(CH_ESC);
      put_byte(CH_CSI);
      put_number(200, 1'b0);
      put_byte(CH_TILDE);
      put_byte(CH_ESC);
      put_byte(CH_CSI);
      put_number(9, 1'b0);
      put_byte(CH_SEMI);
      put_number(9, 1'b0);
      put_byte(CH_R);
      put_byte(CH_ESC);
      put_byte(CH_CSI);
      put_byte(CH_Z);

      target = sent_count + 220;
      while (sent_count < target) random_sequence();

      foreach (phase_values[p]) begin
         settle_and_write(phase_values[p]);
         send_style  = setting_count % 3;
         stall_style = (setting_count + 1) % 4;
         target = sent_count + 200;
         while (sent_count < target) random_sequence();
      end

      wait_idle();
      $display("tekd: %0d byte and tick requests over %0d gap timeout settings,",
               sent_count, setting_count + 1);
      $display("tekd: %0d key events compared", event_count);
      if (fail_count == 0 && pending_count == 0)
         $display("[terminal_escape_key_decoder_top] OK");
      else
         $display("[terminal_escape_key_decoder_top] ERROR");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("[terminal_escape_key_decoder_top] ERROR");
      $finish;
   end

endmodule
